// ===== rtl/core/two_level_lru_cache_tags_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TWO_LEVEL_LRU_CACHE_TAGS_MACROS_SVH
`define TWO_LEVEL_LRU_CACHE_TAGS_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/tlc_pkg.sv =====
// Package with shared constants and types for the two-level cache tag block.
`default_nettype none
package tlc_pkg;
  localparam int MAX_ROWS  = 256;
  localparam int MAX_WAYS  = 16;
  localparam int ADDR_BITS = 13;
  localparam int MAX_BSHIFT = 6;

  localparam logic [1:0] EV_HIT   = 2'd0;
  localparam logic [1:0] EV_MISS  = 2'd1;
  localparam logic [1:0] EV_STORE = 2'd2;

  localparam logic [2:0] CFG_TWO_LEVELS = 3'd0;
  localparam logic [2:0] CFG_L1_BSHIFT  = 3'd1;
  localparam logic [2:0] CFG_L1_RSHIFT  = 3'd2;
  localparam logic [2:0] CFG_L1_WAYS    = 3'd3;
  localparam logic [2:0] CFG_L2_BSHIFT  = 3'd4;
  localparam logic [2:0] CFG_L2_RSHIFT  = 3'd5;
  localparam logic [2:0] CFG_L2_WAYS    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the input beat
    logic sel_l2;     // level worked on by the steps below
    logic clr_step;   // clear the way counter and the scan state
    logic fetch;      // read the next way of the row
    logic decide;     // settle hit and victim
    logic wr_step;    // write back one way
  } tlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic wr_done;
    logic clr_done;
    logic hit;
    logic is_store;
  } tlc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/tlc_ctrl.sv =====
// Controller state machine for the two-level cache tag block.
`default_nettype none
module tlc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_level,
  output logic                 out_last,
  output logic                 out_is_l2_hit,
  input  wire logic            two_levels,
  input  wire tlc_pkg::tlc_sts_t sts,
  output tlc_pkg::tlc_cmd_t    cmd
);
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SCAN1 = 4'd2;
  localparam logic [3:0] ST_DEC1  = 4'd3;
  localparam logic [3:0] ST_WR1   = 4'd4;
  localparam logic [3:0] ST_SCAN2 = 4'd5;
  localparam logic [3:0] ST_DEC2  = 4'd6;
  localparam logic [3:0] ST_WR2   = 4'd7;
  localparam logic [3:0] ST_OUT1  = 4'd8;
  localparam logic [3:0] ST_OUT2  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       two_r, two_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      two_r   <= two_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    two_nxt   = two_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    out_level = 1'b0;
    out_last  = 1'b0;
    out_is_l2_hit = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.clr_step = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          two_nxt   = two_levels;
          state_nxt = ST_SCAN1;
        end
      end
      ST_SCAN1: begin
        // The last way read is folded in the decide step, so no read follows it.
        if (sts.scan_done) begin
          state_nxt = ST_DEC1;
        end else begin
          cmd.fetch = 1'b1;
        end
      end
      ST_DEC1: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_WR1;
      end
      ST_WR1: begin
        cmd.wr_step = 1'b1;
        if (sts.wr_done) begin
          cmd.clr_step = 1'b1;
          state_nxt = (two_r && (sts.is_store || !sts.hit)) ? ST_SCAN2 : ST_OUT1;
        end
      end
      ST_SCAN2: begin
        cmd.sel_l2 = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DEC2;
        end else begin
          cmd.fetch = 1'b1;
        end
      end
      ST_DEC2: begin
        cmd.sel_l2 = 1'b1;
        cmd.decide = 1'b1;
        state_nxt  = ST_WR2;
      end
      ST_WR2: begin
        cmd.sel_l2  = 1'b1;
        cmd.wr_step = 1'b1;
        if (sts.wr_done) begin
          state_nxt = ST_OUT1;
        end
      end
      ST_OUT1: begin
        out_valid = 1'b1;
        out_last  = !(two_r && (sts.is_store || !sts.hit));
        if (!out_stall) begin
          state_nxt = out_last ? ST_IDLE : ST_OUT2;
        end
      end
      ST_OUT2: begin
        out_valid = 1'b1;
        out_level = 1'b1;
        out_last  = 1'b1;
        out_is_l2_hit = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/tlc_dp.sv =====
// Datapath for the two-level cache tag block: tag memories, age search, updates.
`default_nettype none
module tlc_dp #(
  parameter int MAX_ROWS  = tlc_pkg::MAX_ROWS,
  parameter int MAX_WAYS  = tlc_pkg::MAX_WAYS,
  parameter int ADDR_BITS = tlc_pkg::ADDR_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tlc_pkg::tlc_cmd_t      cmd,
  output tlc_pkg::tlc_sts_t           sts,
  input  wire logic                   in_req_type,
  input  wire logic [ADDR_BITS-1:0]   in_address,
  input  wire logic [15:0]            in_pc,
  input  wire logic [2:0]             l1_bshift,
  input  wire logic [3:0]             l1_rshift,
  input  wire logic [4:0]             l1_ways,
  input  wire logic [2:0]             l2_bshift,
  input  wire logic [3:0]             l2_rshift,
  input  wire logic [4:0]             l2_ways,
  input  wire logic                   out_level,
  input  wire logic                   out_is_l2_hit,
  output logic [1:0]                  out_event_res,
  output logic [15:0]                 out_pc_out,
  output logic [ADDR_BITS-1:0]        out_address_out,
  output logic [7:0]                  out_row
);
  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_WAYS;
  localparam int IB    = $clog2(DEPTH * 2);
  localparam int CB    = $clog2(DEPTH * 2 + 1);
  localparam int MAXRS = $clog2(MAX_ROWS);

  // Both levels share one memory; the top index bit selects the level.
  logic [ADDR_BITS-1:0] tag_mem [DEPTH*2];
  logic [3:0]           age_mem [DEPTH*2];
  logic                 val_mem [DEPTH*2];

  // Ages and valid bits of the row in work, kept from the scan for the write-back.
  logic [3:0]           way_age_r [MAX_WAYS];
  logic                 way_val_r [MAX_WAYS];

  logic                 store_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [15:0]          pc_r;
  logic [RB-1:0]        row_r;
  logic [RB-1:0]        row1_r, row2_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [4:0]           nways_r;
  logic                 lvl_r;
  logic [WB:0]          step_r;     // way counter, one wider to hold the count
  logic [WB:0]          rd_r;       // way whose data sits in the read registers
  logic                 rd_vld_r;
  logic [ADDR_BITS-1:0] rtag_r;
  logic [3:0]           rage_r;
  logic                 rval_r;
  logic                 hit_r, hit1_r, hit2_r;
  logic [WB-1:0]        hway_r, free_r, lru_r;
  logic                 hfound_r, ffound_r;
  logic [3:0]           hage_r, best_r;
  logic [WB-1:0]        vict_r;
  logic [CB-1:0]        clr_r;
  logic                 clr_done_r;

  // Split of the captured address for the level in work.
  logic [2:0]             bs;
  logic [3:0]             rs;
  logic [4:0]             wy;
  logic [ADDR_BITS-1:0]   blk;
  logic [RB-1:0]          row_c;
  logic [ADDR_BITS-1:0]   tag_c;
  logic [4:0]             nw_c;
  logic [IB-1:0]          rd_idx, wr_idx;

  always_comb begin
    bs = cmd.sel_l2 ? l2_bshift : l1_bshift;
    rs = cmd.sel_l2 ? l2_rshift : l1_rshift;
    wy = cmd.sel_l2 ? l2_ways : l1_ways;
    if (bs > 3'(tlc_pkg::MAX_BSHIFT)) bs = 3'(tlc_pkg::MAX_BSHIFT);
    if (32'(rs) > MAXRS) rs = 4'(MAXRS);
    nw_c = (wy == 5'd0) ? 5'd1 : ((32'(wy) > MAX_WAYS) ? 5'(MAX_WAYS) : wy);
    blk  = addr_r >> bs;
    row_c = RB'(blk & ((ADDR_BITS'(1) << rs) - ADDR_BITS'(1)));
    tag_c = blk >> rs;
  end

  assign rd_idx = {cmd.sel_l2, (rd_vld_r ? row_r : row_c), step_r[WB-1:0]};
  assign wr_idx = {lvl_r, row_r, step_r[WB-1:0]};

  assign sts.scan_done = rd_vld_r && (32'(rd_r) + 1 >= 32'(nways_r));
  assign sts.wr_done   = (32'(step_r) + 1 >= 32'(nways_r));
  assign sts.clr_done  = clr_done_r;
  assign sts.hit       = hit1_r;
  assign sts.is_store  = store_r;

  // Reset sweep of the valid bits, two levels in one pass; then the victim's valid bit on write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      val_mem[clr_r[IB-1:0]] <= 1'b0;
      clr_r <= clr_r + CB'(1);
      if (32'(clr_r) == DEPTH * 2 - 1) clr_done_r <= 1'b1;
    end else if (cmd.wr_step) begin
      if (32'(step_r) < 32'(nways_r) &&
          ((WB+1)'(vict_r) == step_r) && !hit_r) begin
        val_mem[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      store_r <= in_req_type;
      addr_r  <= in_address;
      pc_r    <= in_pc;
    end
    if (cmd.clr_step) begin
      step_r   <= '0;
      rd_vld_r <= 1'b0;
      hfound_r <= 1'b0;
      ffound_r <= 1'b0;
      best_r   <= '0;
      lru_r    <= '0;
    end else if (cmd.fetch) begin
      if (!rd_vld_r) begin
        row_r   <= row_c;
        tag_r   <= tag_c;
        nways_r <= nw_c;
        lvl_r   <= cmd.sel_l2;
        if (cmd.sel_l2) row2_r <= row_c; else row1_r <= row_c;
      end
      rtag_r   <= tag_mem[rd_idx];
      rage_r   <= age_mem[rd_idx];
      rval_r   <= val_mem[rd_idx];
      rd_r     <= step_r;
      rd_vld_r <= 1'b1;
      step_r   <= step_r + (WB+1)'(1);
      if (rd_vld_r) begin
        // Fold the way read in the previous cycle.
        way_age_r[rd_r[WB-1:0]] <= rage_r;
        way_val_r[rd_r[WB-1:0]] <= rval_r;
        if (!hfound_r && rval_r && rtag_r == tag_r) begin
          hfound_r <= 1'b1;
          hway_r   <= rd_r[WB-1:0];
          hage_r   <= rage_r;
        end
        if (!ffound_r && !rval_r) begin
          ffound_r <= 1'b1;
          free_r   <= rd_r[WB-1:0];
        end
        if (rd_r == '0 || rage_r > best_r) begin
          best_r <= rage_r;
          lru_r  <= rd_r[WB-1:0];
        end
      end
    end else if (cmd.decide) begin
      // Last way read is folded here as well.
      logic h, f;
      logic [WB-1:0] hw, fw, lw;
      logic [3:0] ha;
      h = hfound_r; f = ffound_r; hw = hway_r; fw = free_r; lw = lru_r; ha = hage_r;
      if (!h && rval_r && rtag_r == tag_r) begin
        h = 1'b1; hw = rd_r[WB-1:0]; ha = rage_r;
      end
      if (!f && !rval_r) begin
        f = 1'b1; fw = rd_r[WB-1:0];
      end
      if (rd_r == '0 || rage_r > best_r) lw = rd_r[WB-1:0];
      way_age_r[rd_r[WB-1:0]] <= rage_r;
      way_val_r[rd_r[WB-1:0]] <= rval_r;
      hit_r  <= h;
      hage_r <= ha;
      vict_r <= h ? hw : (f ? fw : lw);
      if (lvl_r) hit2_r <= h; else hit1_r <= h;
      step_r <= '0;
    end else if (cmd.wr_step) begin
      step_r <= step_r + (WB+1)'(1);
    end
  end

  // Write-back: one way a cycle, age update from the scanned copy and the victim tag.
  logic [3:0] wage, wage_nxt;
  logic       wval;
  assign wage = way_age_r[step_r[WB-1:0]];
  assign wval = way_val_r[step_r[WB-1:0]];
  always_comb begin
    wage_nxt = wage;
    if ((WB+1)'(vict_r) == step_r) begin
      wage_nxt = 4'd0;
    end else if (wval && wage != 4'd15 && (!hit_r || wage < hage_r)) begin
      wage_nxt = wage + 4'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.wr_step && 32'(step_r) < 32'(nways_r)) begin
      age_mem[wr_idx] <= wage_nxt;
      if ((WB+1)'(vict_r) == step_r && !hit_r) tag_mem[wr_idx] <= tag_r;
    end
  end

  always_comb begin
    out_pc_out      = pc_r;
    out_address_out = addr_r;
    out_row         = 8'(out_level ? row2_r : row1_r);
    if (store_r) out_event_res = tlc_pkg::EV_STORE;
    else if (out_is_l2_hit) out_event_res = hit2_r ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS;
    else out_event_res = hit1_r ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS;
  end
endmodule
`default_nettype wire

// ===== rtl/core/two_level_lru_cache_tags.sv =====
// Each access is accepted, then each level touched is scanned, decided and written
// back one way at a time, then one result beat per level touched is offered.
// One access at a time: a new access is taken only after the last result beat.
// The way scan over the tag, age and valid memories paces each access.
// After reset a sweep clears the valid bits of both levels
// while no access is taken; configuration writes are taken throughout.
`default_nettype none
module two_level_lru_cache_tags #(
  parameter int MAX_ROWS  = tlc_pkg::MAX_ROWS,
  parameter int MAX_WAYS  = tlc_pkg::MAX_WAYS,
  parameter int ADDR_BITS = tlc_pkg::ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [ADDR_BITS-1:0] in_address,
  input  wire logic [15:0]          in_pc,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_level,
  output logic [1:0]                out_event_res,
  output logic [15:0]               out_pc_out,
  output logic [ADDR_BITS-1:0]      out_address_out,
  output logic [7:0]                out_row,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [4:0]           cfg_data
);
  // Configuration registers, reset to a single direct-mapped first level.
  logic       two_r;
  logic [2:0] l1b_r, l2b_r;
  logic [3:0] l1r_r, l2r_r;
  logic [4:0] l1w_r, l2w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_r <= 1'b0;
      l1b_r <= '0; l1r_r <= '0; l1w_r <= 5'd1;
      l2b_r <= '0; l2r_r <= '0; l2w_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tlc_pkg::CFG_TWO_LEVELS: two_r <= cfg_data[0];
        tlc_pkg::CFG_L1_BSHIFT:  l1b_r <= cfg_data[2:0];
        tlc_pkg::CFG_L1_RSHIFT:  l1r_r <= cfg_data[3:0];
        tlc_pkg::CFG_L1_WAYS:    l1w_r <= cfg_data;
        tlc_pkg::CFG_L2_BSHIFT:  l2b_r <= cfg_data[2:0];
        tlc_pkg::CFG_L2_RSHIFT:  l2r_r <= cfg_data[3:0];
        tlc_pkg::CFG_L2_WAYS:    l2w_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tlc_pkg::tlc_cmd_t cmd;
  tlc_pkg::tlc_sts_t sts;
  logic is_l2_hit;

  // The controller sequences each level as scan, decide, then write-back.
  tlc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_level, .out_last, .out_is_l2_hit(is_l2_hit),
    .two_levels(two_r), .sts, .cmd
  );

  // The datapath holds both tag stores and the captured access beat.
  tlc_dp #(.MAX_ROWS(MAX_ROWS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_req_type, .in_address, .in_pc,
    .l1_bshift(l1b_r), .l1_rshift(l1r_r), .l1_ways(l1w_r),
    .l2_bshift(l2b_r), .l2_rshift(l2r_r), .l2_ways(l2w_r),
    .out_level, .out_is_l2_hit(is_l2_hit), .out_event_res, .out_pc_out,
    .out_address_out, .out_row
  );
endmodule
`default_nettype wire

// ===== rtl/core/tlc_checker.sv =====
// Port-level checker for the two-level cache tag block, with its bind.
`default_nettype none
`include "two_level_lru_cache_tags_macros.svh"
module tlc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_level,
  input wire logic [1:0] out_event_res,
  input wire logic       out_last
);
  `TLC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_valid && !in_stall, !out_valid, "input taken while result pending")
  `TLC_ASSERT_IMP(a_l2_is_last, clk, rst_n, out_valid && out_level, out_last, "second level beat not last")
  `TLC_ASSERT_IMP(a_ev_code, clk, rst_n, out_valid, out_event_res != 2'd3, "bad event code")
  `TLC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_level), "stalled beat changed")
endmodule
bind two_level_lru_cache_tags tlc_checker u_tlc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_level, .out_event_res, .out_last
);
`default_nettype wire

// ===== verif/tlc_scoreboard.sv =====
// Scoreboard class: tag and recency predictor for both cache levels plus result checking.
class tlc_scoreboard;
  typedef struct {
    bit        level;
    bit [1:0]  ev;
    bit [15:0] pc;
    bit [12:0] addr;
    bit [7:0]  row;
    bit        last;
  } access_event_t;

  bit [12:0] tag_mem [2][tlc_pkg::MAX_ROWS*tlc_pkg::MAX_WAYS];
  bit        vld_mem [2][tlc_pkg::MAX_ROWS*tlc_pkg::MAX_WAYS];
  bit [3:0]  age_mem [2][tlc_pkg::MAX_ROWS*tlc_pkg::MAX_WAYS];
  bit        dual_level;
  int        blk_sh [2];
  int        row_sh [2];
  int        way_cnt [2];
  access_event_t events_due [$];
  int        mismatches;

  function new();
    dual_level = 0;
    blk_sh = '{0, 0};
    row_sh = '{0, 0};
    way_cnt = '{1, 1};
    mismatches = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [4:0] val);
    case (idx)
      tlc_pkg::CFG_TWO_LEVELS: dual_level = val[0];
      tlc_pkg::CFG_L1_BSHIFT:  blk_sh[0] = val[2:0];
      tlc_pkg::CFG_L1_RSHIFT:  row_sh[0] = val[3:0];
      tlc_pkg::CFG_L1_WAYS:    way_cnt[0] = val;
      tlc_pkg::CFG_L2_BSHIFT:  blk_sh[1] = val[2:0];
      tlc_pkg::CFG_L2_RSHIFT:  row_sh[1] = val[3:0];
      tlc_pkg::CFG_L2_WAYS:    way_cnt[1] = val;
      default: ;
    endcase
  endfunction

  // Looks one level up, updating tags and recency; returns 1 on a hit.
  function bit probe(int lv, bit [12:0] addr, output int row);
    int bs, rs, nw, blk, tag, base, hw, victim, best;
    bit hit, free_found;
    bit [3:0] a;
    bs = (blk_sh[lv] > tlc_pkg::MAX_BSHIFT) ? tlc_pkg::MAX_BSHIFT : blk_sh[lv];
    rs = (row_sh[lv] > 8) ? 8 : row_sh[lv];
    nw = (way_cnt[lv] == 0) ? 1 : (way_cnt[lv] > tlc_pkg::MAX_WAYS) ?
         tlc_pkg::MAX_WAYS : way_cnt[lv];
    blk = addr >> bs;
    row = blk & ((1 << rs) - 1);
    tag = (blk >> rs) & 8191;
    base = row * tlc_pkg::MAX_WAYS;
    hit = 0;
    hw = 0;
    for (int w = 0; w < nw; w++) begin
      if (!hit && vld_mem[lv][base+w] && tag_mem[lv][base+w] == tag) begin
        hit = 1;
        hw = w;
      end
    end
    if (hit) begin
      a = age_mem[lv][base+hw];
      for (int w = 0; w < nw; w++)
        if (w != hw && vld_mem[lv][base+w] && age_mem[lv][base+w] < a &&
            age_mem[lv][base+w] < 15)
          age_mem[lv][base+w]++;
      age_mem[lv][base+hw] = 0;
      return 1;
    end
    free_found = 0;
    victim = 0;
    for (int w = 0; w < nw; w++) begin
      if (!free_found && !vld_mem[lv][base+w]) begin
        free_found = 1;
        victim = w;
      end
    end
    if (!free_found) begin
      best = 0;
      for (int w = 0; w < nw; w++)
        if (w == 0 || int'(age_mem[lv][base+w]) > best) begin
          best = int'(age_mem[lv][base+w]);
          victim = w;
        end
    end
    for (int w = 0; w < nw; w++)
      if (vld_mem[lv][base+w] && age_mem[lv][base+w] < 15) age_mem[lv][base+w]++;
    tag_mem[lv][base+victim] = 13'(tag);
    vld_mem[lv][base+victim] = 1;
    age_mem[lv][base+victim] = 0;
    return 0;
  endfunction

  function void push_event(bit lv, bit [1:0] ev, bit [15:0] pc, bit [12:0] addr,
                           int row, bit last);
    access_event_t e;
    e.level = lv;
    e.ev = ev;
    e.pc = pc;
    e.addr = addr;
    e.row = 8'(row);
    e.last = last;
    events_due = {events_due, e};
  endfunction

  function void note_access(bit is_store, bit [12:0] addr, bit [15:0] pc);
    int r1, r2;
    bit h1, h2;
    h1 = probe(0, addr, r1);
    if (is_store) begin
      if (dual_level) begin
        h2 = probe(1, addr, r2);
        push_event(0, tlc_pkg::EV_STORE, pc, addr, r1, 0);
        push_event(1, tlc_pkg::EV_STORE, pc, addr, r2, 1);
      end else begin
        push_event(0, tlc_pkg::EV_STORE, pc, addr, r1, 1);
      end
    end else if (!h1 && dual_level) begin
      h2 = probe(1, addr, r2);
      push_event(0, tlc_pkg::EV_MISS, pc, addr, r1, 0);
      push_event(1, h2 ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS, pc, addr, r2, 1);
    end else begin
      push_event(0, h1 ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS, pc, addr, r1, 1);
    end
  endfunction

  task report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task check_beat(bit lv, bit [1:0] ev, bit [15:0] pc, bit [12:0] addr,
                  bit [7:0] row, bit last);
    access_event_t e;
    if (events_due.size() == 0) begin
      report("unexpected result beat", 1, 0);
      return;
    end
    e = events_due.pop_front();
    if (lv != e.level) report("level", lv, e.level);
    if (ev != e.ev) report("event_res", ev, e.ev);
    if (pc != e.pc) report("pc_out", pc, e.pc);
    if (addr != e.addr) report("address_out", addr, e.addr);
    if (row != e.row) report("row", row, e.row);
    if (last != e.last) report("last", last, e.last);
  endtask

  function int pending();
    return events_due.size();
  endfunction
endclass

// ===== verif/tb_top.sv =====
// Top-level testbench for the two-level LRU cache tag block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: the valid sweep plus every access at its slowest, several times over.
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_req_type = 0;
  logic [12:0] in_address = '0;
  logic [15:0] in_pc = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_level;
  logic [1:0]  out_event_res;
  logic [15:0] out_pc_out;
  logic [12:0] out_address_out;
  logic [7:0]  out_row;
  logic        out_last;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  tlc_scoreboard cache_sb = new();
  int cycles = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  int addr_pool [16];

  two_level_lru_cache_tags dut (.*);

  always #6 clk = ~clk;

  // Cycle counter; it also ends a run that hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The long receiver hold-off counts itself down here, one cycle per edge.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left--;
  end

  // Result side: check each accepted beat, then choose the stall for the next cycle.
  // Signals read here at the edge still carry their values from before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      cache_sb.check_beat(out_level, out_event_res, out_pc_out, out_address_out,
                          out_row, out_last);
    if (hold_left > 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // Offers one access and waits for the beat to be taken; the predictor is updated
  // at the edge that accepts it.
  task send_access(bit is_store, bit [12:0] addr, bit [15:0] pc);
    in_valid <= 1'b1;
    in_req_type <= is_store;
    in_address <= addr;
    in_pc <= pc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cache_sb.note_access(is_store, addr, pc);
  endtask

  // Random sender gaps between beats.
  task sender_gap();
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every expected result has come back.
  task drain();
    in_valid <= 1'b0;
    while (cache_sb.pending() > 0) @(posedge clk);
  endtask

  // Registers are written only with the block idle, once every result has come back;
  // a short margin is left first.
  task program_cache(bit two, int b1, int r1, int w1, int b2, int r2, int w2);
    bit [4:0] vals [7];
    drain();
    repeat (100) @(posedge clk);
    vals = '{5'(two), 5'(b1), 5'(r1), 5'(w1), 5'(b2), 5'(r2), 5'(w2)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      cache_sb.write_reg(i[2:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random accesses. Most addresses come from a small pool so that rows refill and
  // both hits and evictions happen; the rest are anywhere in the address space.
  task random_phase(int n, bit pause_midway);
    bit [12:0] a;
    foreach (addr_pool[i]) addr_pool[i] = $urandom_range(8191);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 70)
        a = 13'(addr_pool[$urandom_range(15)] ^ $urandom_range(3));
      else
        a = 13'($urandom_range(8191));
      send_access(1'($urandom_range(1)), a, 16'($urandom_range(65535)));
      if (pause_midway && k == n / 2) drain();
      sender_gap();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed accesses: both levels on, small rows so that the second level matters.
    program_cache(1'b1, 0, 2, 2, 1, 3, 4);
    send_access(1'b0, 13'd0, 16'h0000);     // cold miss at both levels
    send_access(1'b0, 13'd0, 16'hffff);     // first level hit
    send_access(1'b1, 13'd8191, 16'hffff);  // store at the top address
    send_access(1'b0, 13'd8191, 16'h1234);  // load hit after the store
    send_access(1'b1, 13'd8191, 16'h0001);  // store hit only refreshes recency
    send_access(1'b0, 13'd4, 16'h0002);     // same row, new tag
    send_access(1'b0, 13'd8, 16'h0003);     // row full: evicts the oldest way
    send_access(1'b0, 13'd0, 16'h0004);     // first level miss, second level hit
    send_access(1'b0, 13'd12, 16'h0005);
    send_access(1'b0, 13'd4, 16'h0006);
    send_access(1'b1, 13'd0, 16'h8000);
    send_access(1'b0, 13'd5, 16'h7fff);     // same block as address 4 at level two
    send_access(1'b0, 13'h1555, 16'haaaa);
    send_access(1'b1, 13'h0aaa, 16'h5555);
    drain();

    // No idling at either side.
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    program_cache(1'b1, 1, 2, 2, 2, 3, 4);
    random_phase(250, 1'b0);

    // Single level, one way, one row, and the sender idling often.
    snd_idle_pct = 57;
    program_cache(1'b0, 0, 0, 1, 0, 0, 1);
    random_phase(200, 1'b0);

    // Largest sizes at both levels, with the receiver stalling often.
    snd_idle_pct = 0;
    rcv_stall_pct = 57;
    program_cache(1'b1, 6, 8, 16, 6, 8, 16);
    random_phase(250, 1'b0);

    // Out-of-range settings that are clamped: block shift 7, oversized row shifts,
    // zero ways and more ways than exist; both sides idle now and then.
    snd_idle_pct = 10;
    rcv_stall_pct = 10;
    program_cache(1'b1, 7, 15, 0, 7, 9, 31);
    random_phase(200, 1'b0);

    // Long receiver hold-off while the sender keeps offering, so the block backs up.
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    program_cache(1'b1, 2, 4, 4, 0, 6, 8);
    hold_left = 400;
    random_phase(300, 1'b0);

    // Fewer ways than before: entries above the new count must be left alone.
    snd_idle_pct = 57;
    program_cache(1'b1, 0, 1, 3, 3, 2, 2);
    random_phase(200, 1'b0);

    snd_idle_pct = 0;
    rcv_stall_pct = 57;
    program_cache(1'b0, 3, 5, 8, 1, 1, 1);
    random_phase(200, 1'b0);

    // Both sides idling, with one pause in which the sender waits for every result.
    snd_idle_pct = 10;
    rcv_stall_pct = 10;
    program_cache(1'b1, 1, 3, 2, 2, 5, 16);
    random_phase(200, 1'b1);

    drain();
    repeat (100) @(posedge clk);
    if (cache_sb.mismatches == 0 && cache_sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
